>>> design/sti_pkg.sv
package sti_pkg;

  localparam int TableDepth = 64;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CountW     = AddrW + 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_CLEAR,
    CMD_RD_POS,
    CMD_SHIFT,
    CMD_INSERT,
    CMD_RD_IDX,
    CMD_NEXT,
    CMD_MATCH,
    CMD_MUL,
    CMD_DIV_START,
    CMD_FINISH,
    CMD_PUSH
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_Q_RD,
    S_Q_CMP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    dp_cmd_e op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    empty;
    logic    full;
    logic    pos_zero;
    logic    idx_zero;
    logic    idx_last;
    logic    ang_eq;
    logic    ang_gt;
    logic    div_done;
    logic    out_free;
  } stat_t;

endpackage

>>> design/sorted_table_linear_interpolator_unit.sv
// Channel   Direction  Transfer when             Payload
// s_axis    in         s_tvalid_i & s_tready_o   opcode, angle, lift
// m_axis    out        m_tvalid_o & m_tready_i   value, status, points_held
//
// One result transfer follows every input transfer, in order.
// Clear and unused opcodes go straight to the output. A load reads and moves up each stored point
// with a larger angle, from the top down, then writes the new point; one memory access a cycle.
// A query scans entries from the bottom and runs the 32-step serial divider when it interpolates.
// Reset clears the point count and the handshake state; table contents need no clearing.
// A stalled output holds its result in a register; the next item waits only for that slot.
module sorted_table_linear_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [1:0] opcode, [17:2] angle, [33:18] lift, [39:34] zero
  input  logic [39:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [15:0] value, [17:16] status, [24:18] points_held, [31:25] zero
  output logic [31:0] m_tdata_o
);
  import sti_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences inserts, scans and the divide; the datapath owns the table.
  sti_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_tvalid_i),
    .in_ready_o(s_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sti_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_tdata_i),
    .out_valid_o(m_tvalid_o),
    .out_ready_i(m_tready_i),
    .out_data_o (m_tdata_o)
  );

endmodule

>>> design/sti_div.sv
module sti_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic        done_o
);

  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] rem_sh;
  logic [16:0] trial;

  // One quotient bit per cycle, restoring method.
  always_comb begin
    rem_sh = {rem_q, quo_q[31]};
    trial  = rem_sh - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> design/sti_dp.sv
module sti_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sti_pkg::cmd_t cmd_i,
  output sti_pkg::stat_t stat_o,
  input  logic [39:0]   in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o
);
  import sti_pkg::*;

  // Each entry holds {angle, lift}.
  logic [31:0] mem_q [TableDepth];
  logic [31:0] rd_q;
  logic        we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0] wdata;
  logic        re;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  opcode_e           op_q;
  logic signed [15:0] ang_q, lift_q;
  logic [31:0]       prev_q;
  logic signed [15:0] res_q;
  logic signed [33:0] prod_q;
  logic [15:0]       den_q;
  logic              out_valid_q;
  logic [31:0]       out_data_q;

  logic signed [15:0] rd_ang, rd_lift, prev_ang, prev_lift;
  logic signed [16:0] dx, dl, da;
  logic [33:0]        prod_abs;
  logic [31:0]        quo;
  logic               div_done;
  logic signed [34:0] qs, sum;
  logic signed [15:0] sat;

  assign rd_ang    = rd_q[31:16];
  assign rd_lift   = rd_q[15:0];
  assign prev_ang  = prev_q[31:16];
  assign prev_lift = prev_q[15:0];
  assign dx        = {rd_ang[15], rd_ang} - {prev_ang[15], prev_ang};
  assign dl        = {rd_lift[15], rd_lift} - {prev_lift[15], prev_lift};
  assign da        = {ang_q[15], ang_q} - {prev_ang[15], prev_ang};
  assign prod_abs  = prod_q[33] ? -prod_q : prod_q;

  sti_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.op == CMD_DIV_START),
    .dividend_i(prod_abs[31:0]),
    .divisor_i (den_q),
    .quotient_o(quo),
    .done_o    (div_done)
  );

  always_comb begin
    qs  = prod_q[33] ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
    sum = qs + 35'(prev_lift);
    if (sum > 35'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -35'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = rd_q;
    waddr = pos_q[AddrW-1:0];
    re    = 1'b0;
    raddr = idx_q;
    case (cmd_i.op)
      CMD_RD_POS: begin
        re    = 1'b1;
        raddr = AddrW'(pos_q - CountW'(1));
      end
      CMD_RD_IDX: re = 1'b1;
      CMD_SHIFT:  we = 1'b1;
      CMD_INSERT: begin
        we    = 1'b1;
        wdata = {ang_q, lift_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    case (cmd_i.op)
      CMD_CAPTURE: begin
        pos_d = count_q;
        idx_d = '0;
      end
      CMD_CLEAR:  count_d = '0;
      CMD_SHIFT:  pos_d = pos_q - CountW'(1);
      CMD_INSERT: count_d = count_q + CountW'(1);
      CMD_NEXT:   idx_d = idx_q + AddrW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.op == CMD_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    case (cmd_i.op)
      CMD_CAPTURE: begin
        op_q   <= opcode_e'(in_data_i[1:0]);
        ang_q  <= in_data_i[17:2];
        lift_q <= in_data_i[33:18];
        res_q  <= '0;
      end
      CMD_NEXT:  prev_q <= rd_q;
      CMD_MATCH: res_q  <= rd_lift;
      CMD_MUL: begin
        prod_q <= 34'(da * dl);
        den_q  <= dx[15:0];
      end
      CMD_FINISH: res_q <= sat;
      CMD_PUSH: out_data_q <= {7'd0, count_q, cmd_i.st, res_q};
      default: ;
    endcase
  end

  always_comb begin
    stat_o.opcode   = op_q;
    stat_o.empty    = (count_q == '0);
    stat_o.full     = (count_q == CountW'(TableDepth));
    stat_o.pos_zero = (pos_q == '0);
    stat_o.idx_zero = (idx_q == '0);
    stat_o.idx_last = ({1'b0, idx_q} == count_q - CountW'(1));
    stat_o.ang_eq   = (rd_ang == ang_q);
    stat_o.ang_gt   = (rd_ang > ang_q);
    stat_o.div_done = div_done;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth))
    else $error("point count beyond table depth");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_INSERT |-> count_q != CountW'(TableDepth))
    else $error("insert into a full table");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_PUSH |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

>>> design/sti_ctrl.sv
module sti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sti_pkg::stat_t stat_i,
  output sti_pkg::cmd_t  cmd_o
);
  import sti_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        st_d    = ST_OK;
        state_d = S_OUT;
        case (stat_i.opcode)
          OP_LOAD: begin
            if (stat_i.full) st_d = ST_FULL;
            else state_d = S_INS_RD;
          end
          OP_QUERY: begin
            if (stat_i.empty) st_d = ST_EMPTY;
            else state_d = S_Q_RD;
          end
          default: ;
        endcase
      end
      S_INS_RD:  state_d = stat_i.pos_zero ? S_OUT : S_INS_CMP;
      S_INS_CMP: state_d = stat_i.ang_gt ? S_INS_RD : S_OUT;
      S_Q_RD:    state_d = S_Q_CMP;
      S_Q_CMP: begin
        if (stat_i.ang_eq) begin
          state_d = S_OUT;
        end else if (stat_i.ang_gt) begin
          if (stat_i.idx_zero) begin
            st_d    = ST_RANGE;
            state_d = S_OUT;
          end else begin
            state_d = S_DIV_GO;
          end
        end else if (stat_i.idx_last) begin
          st_d    = ST_RANGE;
          state_d = S_OUT;
        end else begin
          state_d = S_Q_RD;
        end
      end
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (stat_i.div_done) state_d = S_OUT;
      S_OUT:      if (stat_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = CMD_NONE;
    cmd_o.st = st_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = CMD_CAPTURE;
      S_DISPATCH: if (stat_i.opcode == OP_CLEAR) cmd_o.op = CMD_CLEAR;
      S_INS_RD:   cmd_o.op = stat_i.pos_zero ? CMD_INSERT : CMD_RD_POS;
      S_INS_CMP:  cmd_o.op = stat_i.ang_gt ? CMD_SHIFT : CMD_INSERT;
      S_Q_RD:     cmd_o.op = CMD_RD_IDX;
      S_Q_CMP: begin
        if (stat_i.ang_eq) cmd_o.op = CMD_MATCH;
        else if (stat_i.ang_gt && !stat_i.idx_zero) cmd_o.op = CMD_MUL;
        else if (!stat_i.ang_gt && !stat_i.idx_last) cmd_o.op = CMD_NEXT;
      end
      S_DIV_GO:   cmd_o.op = CMD_DIV_START;
      S_DIV_WAIT: if (stat_i.div_done) cmd_o.op = CMD_FINISH;
      S_OUT:      if (stat_i.out_free) cmd_o.op = CMD_PUSH;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> tb/sorted_table_linear_interpolator_scoreboard.sv
`timescale 1ns / 100ps

module sorted_table_linear_interpolator_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import sti_pkg::*;

  typedef struct packed {
    logic [6:0]  points_held;
    status_e     status;
    logic [15:0] value;
  } lift_result_t;

  logic signed [15:0] angle_tab [TableDepth];
  logic signed [15:0] lift_tab  [TableDepth];
  int                 held;
  lift_result_t       lift_results_due [$];

  function automatic logic signed [15:0] interpolate(input logic signed [15:0] x);
    longint num, den, sum;
    for (int i = 0; i < held; i++) begin
      if (angle_tab[i] == x) return lift_tab[i];
    end
    for (int i = 0; i + 1 < held; i++) begin
      if (x > angle_tab[i] && x < angle_tab[i+1]) begin
        num = (longint'(x) - longint'(angle_tab[i])) *
              (longint'(lift_tab[i+1]) - longint'(lift_tab[i]));
        den = longint'(angle_tab[i+1]) - longint'(angle_tab[i]);
        sum = longint'(lift_tab[i]) + num / den;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        return sum[15:0];
      end
    end
    return '0;
  endfunction

  // Updates the table copy and returns the result the block owes for this transfer.
  function automatic lift_result_t apply_item(input logic [39:0] d);
    opcode_e            op;
    logic signed [15:0] ang, lf;
    lift_result_t       r;
    int                 pos;
    op  = opcode_e'(d[1:0]);
    ang = d[17:2];
    lf  = d[33:18];
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: held = 0;
      OP_LOAD: begin
        if (held >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = held;
          while (pos > 0 && angle_tab[pos-1] > ang) begin
            angle_tab[pos] = angle_tab[pos-1];
            lift_tab[pos]  = lift_tab[pos-1];
            pos--;
          end
          angle_tab[pos] = ang;
          lift_tab[pos]  = lf;
          held++;
        end
      end
      OP_QUERY: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (ang < angle_tab[0] || ang > angle_tab[held-1]) r.status = ST_RANGE;
        else r.value = interpolate(ang);
      end
      default: ;
    endcase
    r.points_held = held[6:0];
    return r;
  endfunction

  assign pending_o = lift_results_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lift_result_t exp_r, got;
    if (!rst_ni) begin
      held = 0;
      fail_count_o <= 0;
      lift_results_due.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        lift_results_due.insert(lift_results_due.size(), apply_item(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[24:0];
        if (lift_results_due.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result transfer: %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = lift_results_due.pop_front();
          if (got !== exp_r || m_tdata_i[31:25] !== '0) begin
            if (fail_count_o < 10)
              $display("Mismatch: value exp %h got %h, status exp %0d got %0d, held exp %0d got %0d",
                       exp_r.value, got.value, exp_r.status, got.status,
                       exp_r.points_held, got.points_held);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sorted_table_linear_interpolator_unit_test.sv
`timescale 1ns / 100ps

module sorted_table_linear_interpolator_unit_test;
  import sti_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  // [1:0] opcode, [17:2] angle, [33:18] lift, [39:34] zero
  logic [39:0] s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  // [15:0] value, [17:16] status, [24:18] points_held, [31:25] zero
  logic [31:0] m_tdata_o;

  int fail_count;
  int pending;
  // Percent chances that the sender or the receiver sits out a cycle.
  int src_idle;
  int sink_idle;
  int items_sent;
  // Angles loaded since the last clear; used only to aim queries at the table.
  logic [15:0] loaded_angles [$];

  sorted_table_linear_interpolator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  sorted_table_linear_interpolator_scoreboard scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver throttles the result channel on every cycle by the current ratio.
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= sink_idle);
  end

  // Presents one item and holds it until the transfer happens. The valid is only
  // lowered when a gap is chosen, so it never sees two updates in one time step.
  task automatic send_item(input opcode_e op, input logic [15:0] ang, input logic [15:0] lf);
    if ($urandom_range(99) < src_idle) begin
      s_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'b0, lf, ang, op};
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
    if (items_sent == 650) begin
      src_idle  = 83;
      sink_idle = 34;
    end else if (items_sent == 1300) begin
      src_idle  = 0;
      sink_idle = 0;
    end
    if (op == OP_CLEAR) loaded_angles.delete();
    if (op == OP_LOAD && loaded_angles.size() < TableDepth)
      loaded_angles.insert(loaded_angles.size(), ang);
  endtask

  // Picks a query angle: mostly on or near a stored point, sometimes anywhere.
  function automatic logic [15:0] aim_angle();
    logic [15:0] a;
    if (loaded_angles.size() == 0) return 16'($urandom);
    a = loaded_angles[$urandom_range(loaded_angles.size() - 1)];
    case ($urandom_range(5))
      0, 1:    return a;
      2, 3:    return a + 16'($signed($urandom_range(512)) - 256);
      4:       return a + 16'($urandom_range(2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n_load, n_query, choice;
    logic [15:0] base;
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    m_tready_i = 1'b0;
    src_idle   = 34;
    sink_idle  = 83;
    items_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme angles and lifts, duplicate angles, exact hits,
    // out-of-range on both sides, the unused opcode and clearing.
    send_item(OP_QUERY, 16'h0000, 16'hFFFF);
    send_item(OP_LOAD,  16'h7FFF, 16'h8000);
    send_item(OP_LOAD,  16'h8000, 16'h7FFF);
    send_item(OP_LOAD,  16'h0000, 16'h1000);
    send_item(OP_LOAD,  16'h0000, 16'hF000);
    send_item(OP_QUERY, 16'h0000, 16'h0000);
    send_item(OP_QUERY, 16'h8000, 16'h0000);
    send_item(OP_QUERY, 16'h7FFF, 16'h0000);
    send_item(OP_QUERY, 16'h0064, 16'h0000);
    send_item(OP_QUERY, 16'hFF9C, 16'h0000);
    send_item(OP_NONE,  16'hFFFF, 16'hFFFF);
    send_item(OP_LOAD,  16'h0100, 16'h7FFF);
    send_item(OP_QUERY, 16'h0080, 16'h0000);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(OP_QUERY, 16'h0000, 16'h0000);
    send_item(OP_LOAD,  16'h0A00, 16'h0800);
    send_item(OP_QUERY, 16'h0A00, 16'h0000);
    send_item(OP_QUERY, 16'h0A01, 16'h0000);
    send_item(OP_QUERY, 16'h09FF, 16'h0000);
    send_item(OP_CLEAR, 16'h0000, 16'h0000);

    // Random: mostly clear, load a table, query it; some raw noise in between.
    while (items_sent < 1950) begin
      choice = $urandom_range(99);
      if (choice < 85) begin
        send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
        // A few tables are overfilled to reach the full-table case.
        n_load  = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(12, 1);
        n_query = $urandom_range(15, 3);
        base    = 16'($urandom);
        for (int i = 0; i < n_load; i++) begin
          // Just under half the tables use a narrow angle window so duplicates occur.
          if (choice < 40) send_item(OP_LOAD, base + 16'($urandom_range(15)), 16'($urandom));
          else send_item(OP_LOAD, 16'($urandom), 16'($urandom));
        end
        for (int i = 0; i < n_query; i++) send_item(OP_QUERY, aim_angle(), 16'($urandom));
      end else begin
        send_item(opcode_e'($urandom_range(3)), 16'($urandom), 16'($urandom));
      end
    end
    s_tvalid_i <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
